@@ rtl/rrdba_pkg.sv @@
// shared types and constants of the round-robin block allocator
package rrdba_pkg;

    // field widths of the stream words
    localparam int OP_W           = 1;
    localparam int DISK_IDX_W     = 3;
    localparam int OFFSET_FIELD_W = 32;
    localparam int STATUS_W       = 2;
    localparam int S_TDATA_W      = 40;
    localparam int M_TDATA_W      = 40;

    // configuration registers
    localparam int DISKS_REG_W = 4;
    localparam int RING_REG_W  = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_DISKS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_ENTRIES = 1'd1;

    localparam logic [DISKS_REG_W-1:0] DISKS_RESET = 4'd1;
    localparam logic [RING_REG_W-1:0]  RING_RESET  = 9'd256;

    // operation codes
    localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RING_FULL = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE,
        S_START,
        S_SCAN,
        S_READ
    } state_t;

endpackage

@@ rtl/rrdba_cmpsub.sv @@
// shared compare and subtract unit used for disk index wrapping
module rrdba_cmpsub #(
    parameter int W = 4
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] result,
    output logic         ge
);
    assign ge     = (a >= b);
    assign result = ge ? (a - b) : a;
endmodule

@@ rtl/round_robin_multi_disk_block_allocator.sv @@
// top level of the round-robin multi-disk free block allocator
//
// One free ring of block offsets per disk, all rings in a single memory of
// MAX_DISKS x RING_DEPTH words. A free word (tuser = 1) appends its offset to
// the named disk's ring; a full ring or a disk index at or beyond MAX_DISKS
// answers status 2. An allocate word (tuser = 0) reduces the start disk (last
// granted + 1) modulo the disk count with a shared compare/subtract unit,
// one subtract per cycle, then visits one disk per cycle until it finds a
// non-empty ring, and pops its head through a registered memory read. An
// allocate makes k wrap subtracts and visits v disks, where v is 1 up to
// disks_in_use and k is 0 or 1 in normal use, 1 when the last granted disk is
// the highest one in use, up to about MAX_DISKS / disks_in_use after the disk
// count shrinks. The input is taken only while the sequencer is idle;
// the result sits in an output register, so the next word is accepted while a
// result waits, and the sequencer only holds if a second result is ready
// before the first was taken. Rings come up empty after reset: head and tail
// pointers reset, the offset memory needs no clearing. Configuration writes
// are always accepted and must only arrive while the block is idle.
module round_robin_multi_disk_block_allocator #(
    parameter int MAX_DISKS    = 8,
    parameter int RING_DEPTH   = 256,
    parameter int OFFSET_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [2:0] disk_index, [34:3] freed_offset, [39:35] zero
    input  logic [rrdba_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] operation
    input  logic [rrdba_pkg::OP_W-1:0]         s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [2:0] granted_disk, [34:3] granted_offset, [39:35] zero
    output logic [rrdba_pkg::M_TDATA_W-1:0]    m_tdata,
    // [1:0] status
    output logic [rrdba_pkg::STATUS_W-1:0]     m_tuser,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rrdba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rrdba_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rrdba_pkg::*;

    // disk index, disk count and ring pointer widths
    localparam int DISK_W    = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;
    localparam int U_W       = (DISK_W + 1 > DISKS_REG_W) ? DISK_W + 1 : DISKS_REG_W;
    localparam int SLOT_W    = $clog2(RING_DEPTH);
    localparam int SIZE_W    = SLOT_W + 1;
    localparam int CMP_W     = (SIZE_W > RING_REG_W) ? SIZE_W : RING_REG_W;
    localparam int ADDR_W    = DISK_W + SLOT_W;
    localparam int MEM_DEPTH = MAX_DISKS * (2 ** SLOT_W);

    // configuration registers
    logic [DISKS_REG_W-1:0] disks_in_use_reg;
    logic [RING_REG_W-1:0]  ring_entries_reg;

    // sequencer and captured word
    state_t                  state_reg, state_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic [DISK_IDX_W-1:0]   disk_reg, disk_next;
    logic [OFFSET_FIELD_W-1:0] offset_reg, offset_next;
    logic [U_W-1:0]          acc_reg, acc_next;       // current / start disk
    logic [U_W-1:0]          cnt_reg, cnt_next;       // disks visited
    logic [DISK_W-1:0]       last_disk_reg, last_disk_next;

    // per-disk ring pointers
    logic [SLOT_W-1:0]       head_reg [MAX_DISKS];
    logic [SLOT_W-1:0]       tail_reg [MAX_DISKS];
    logic                    head_we, tail_we;

    // offset memory
    logic [OFFSET_WIDTH-1:0] mem [MEM_DEPTH];
    logic                    mem_we, mem_re;
    logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
    logic [OFFSET_WIDTH-1:0] mem_wdata;
    logic [OFFSET_WIDTH-1:0] rd_data_reg;

    // output register
    logic                    m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [DISK_IDX_W-1:0]   gdisk_reg, gdisk_next;
    logic [OFFSET_FIELD_W-1:0] goff_reg, goff_next;

    // helpers
    logic [U_W-1:0]          eff_n, du;
    logic [CMP_W-1:0]        eff_size, re_ext, adv_sum;
    logic [SLOT_W-1:0]       adv_in, ptr_adv, cur_head, cur_tail;
    logic [DISK_W-1:0]       sel;
    logic [7:0]              di8;
    logic                    disk_bad, out_free, non_empty;
    logic [U_W-1:0]          unit_a, unit_res;
    logic                    unit_ge;
    logic [U_W+DISK_IDX_W-1:0] dext;
    logic [OFFSET_WIDTH+OFFSET_FIELD_W-1:0] off_in_ext, off_out_ext;

    // effective disk count, clamped to 1..MAX_DISKS
    always_comb
    begin
        du = U_W'(disks_in_use_reg);
        if (du == '0)
            eff_n = U_W'(1);
        else if (du > U_W'(MAX_DISKS))
            eff_n = U_W'(MAX_DISKS);
        else
            eff_n = du;
    end

    // effective ring size, clamped to 2..RING_DEPTH
    always_comb
    begin
        re_ext = CMP_W'(ring_entries_reg);
        if (re_ext < CMP_W'(2))
            eff_size = CMP_W'(2);
        else if (re_ext > CMP_W'(RING_DEPTH))
            eff_size = CMP_W'(RING_DEPTH);
        else
            eff_size = re_ext;
    end

    // disk being looked at: the freed disk or the scan position
    assign di8      = {5'b00000, disk_reg};
    assign disk_bad = (di8 >= 8'(MAX_DISKS));
    assign sel      = (state_reg == S_FREE) ? di8[DISK_W-1:0] : acc_reg[DISK_W-1:0];
    assign cur_head = head_reg[sel];
    assign cur_tail = tail_reg[sel];
    assign non_empty = (cur_head != cur_tail);

    // pointer advance, wraps to zero at the ring size (also when beyond it)
    assign adv_in  = (state_reg == S_FREE) ? cur_tail : cur_head;
    assign adv_sum = CMP_W'(adv_in) + CMP_W'(1);
    assign ptr_adv = (adv_sum >= eff_size) ? '0 : adv_sum[SLOT_W-1:0];

    // shared wrap unit: modulo reduction of the start disk, then scan step
    assign unit_a = (state_reg == S_SCAN) ? (acc_reg + U_W'(1)) : acc_reg;

    rrdba_cmpsub #(
        .W (U_W)
    ) u_cmpsub (
        .a      (unit_a),
        .b      (eff_n),
        .result (unit_res),
        .ge     (unit_ge)
    );

    // offset width conversion in and out of the memory
    assign off_in_ext  = {{OFFSET_WIDTH{1'b0}}, offset_reg};
    assign off_out_ext = {{OFFSET_FIELD_W{1'b0}}, rd_data_reg};
    assign dext        = {{DISK_IDX_W{1'b0}}, acc_reg};

    assign out_free = ~m_valid_reg | m_tready;

    // sequencer: next state, register next values and memory controls
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        disk_next      = disk_reg;
        offset_next    = offset_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        last_disk_next = last_disk_reg;
        m_valid_next   = m_valid_reg & ~m_tready;
        status_next    = status_reg;
        gdisk_next     = gdisk_reg;
        goff_next      = goff_reg;
        head_we        = 1'b0;
        tail_we        = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = {sel, cur_tail};
        mem_raddr      = {sel, cur_head};
        mem_wdata      = off_in_ext[OFFSET_WIDTH-1:0];
        s_tready       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op_next     = s_tuser;
                    disk_next   = s_tdata[DISK_IDX_W-1:0];
                    offset_next = s_tdata[DISK_IDX_W +: OFFSET_FIELD_W];
                    acc_next    = U_W'(last_disk_reg) + U_W'(1);
                    cnt_next    = '0;
                    state_next  = (s_tuser == OP_FREE) ? S_FREE : S_START;
                end
            end

            S_FREE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    gdisk_next   = '0;
                    goff_next    = '0;
                    if (disk_bad || (ptr_adv == cur_head))
                        status_next = ST_RING_FULL;
                    else
                    begin
                        status_next = ST_OK;
                        mem_we      = 1'b1;
                        tail_we     = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end

            S_START:
            begin
                // one subtract per cycle until below the disk count
                if (unit_ge)
                    acc_next = unit_res;
                else
                    state_next = S_SCAN;
            end

            S_SCAN:
            begin
                if (non_empty)
                begin
                    mem_re         = 1'b1;
                    head_we        = 1'b1;
                    last_disk_next = sel;
                    state_next     = S_READ;
                end
                else if ((cnt_reg + U_W'(1)) == eff_n)
                begin
                    if (out_free)
                    begin
                        m_valid_next = 1'b1;
                        status_next  = ST_NO_FREE;
                        gdisk_next   = '0;
                        goff_next    = '0;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    acc_next = unit_res;
                    cnt_next = cnt_reg + U_W'(1);
                end
            end

            S_READ:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    status_next  = ST_OK;
                    gdisk_next   = dext[DISK_IDX_W-1:0];
                    goff_next    = off_out_ext[OFFSET_FIELD_W-1:0];
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_disk_reg <= '0;
            m_valid_reg   <= 1'b0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            last_disk_reg <= last_disk_next;
            m_valid_reg   <= m_valid_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        disk_reg   <= disk_next;
        offset_reg <= offset_next;
        status_reg <= status_next;
        gdisk_reg  <= gdisk_next;
        goff_reg   <= goff_next;
    end

    // ring pointers, all rings empty after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_DISKS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            if (head_we)
                head_reg[sel] <= ptr_adv;
            if (tail_we)
                tail_reg[sel] <= ptr_adv;
        end
    end

    // offset memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    // configuration registers, writes always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disks_in_use_reg <= DISKS_RESET;
            ring_entries_reg <= RING_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DISKS_IN_USE: disks_in_use_reg <= cfg_data[DISKS_REG_W-1:0];
                CFG_RING_ENTRIES: ring_entries_reg <= cfg_data[RING_REG_W-1:0];
                default:          ;
            endcase
        end
    end

    // result stream
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - OFFSET_FIELD_W - DISK_IDX_W){1'b0}}, goff_reg, gdisk_reg};
    assign m_tuser  = status_reg;

`ifndef SYNTHESIS
    // no-free result carries no disk and no offset
    a_nofree_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_NO_FREE)) |-> (m_tdata == '0))
        else $error("no-free result with nonzero data");

    // the scan position and visit count stay below the disk count
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ((acc_reg < eff_n) && (cnt_reg < eff_n)))
        else $error("scan position out of range");

    // an accepted free word goes straight to the ring update
    a_free_path: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == OP_FREE)) |=> (state_reg == S_FREE))
        else $error("free word did not reach the ring update");

    // a successful allocate always moves last_disk to the granted disk
    a_grant_last: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) && non_empty) |=>
            ((state_reg == S_READ) && (last_disk_reg == $past(sel))))
        else $error("grant did not update last disk");
`endif

endmodule
